// File: hdl/swrl_pkg.sv
// Shared types, constants and the rainbow pattern for the single-wire RGB LED sender.
`default_nettype none
package swrl_pkg;

  localparam int TIMER_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int ADDR_WIDTH      = 5;
  localparam int DATA_WIDTH      = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PULSE_HIGH = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd1;
  localparam logic [2:0] REG_ONE_LOW    = 3'd2;
  localparam logic [2:0] REG_END_LOW    = 3'd3;
  localparam logic [2:0] REG_COMMAND    = 3'd4;

  // Input actions
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SEND    = 2'd1;
  localparam logic [1:0] ACT_RAINBOW = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // Classified operations handed to the back end
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;
  localparam logic [1:0] OP_RAINBOW = 2'd3;

  localparam int FRAME_LEN = 34;
  localparam int RAINBOW_LEN = 12;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } op_item_t;

  typedef struct packed {
    logic [7:0] pulse_high_ticks;
    logic [7:0] zero_low_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] end_low_ticks;
    logic [7:0] command_byte;
  } cfg_t;

  function automatic logic [7:0] rainbow_color(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd10, 4'd11: c = 8'hff;
      4'd3, 4'd9:                     c = 8'h80;
      default:                        c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/swrl_fifo.sv
// Small register queue used between the front end, back end and result port.
`default_nettype none
module swrl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/swrl_front.sv
// Front end: accepts input items and classifies them into back-end operations.
`default_nettype none
module swrl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire swrl_pkg::in_item_t item,
  output logic                    q_push,
  input  wire logic               q_full,
  output swrl_pkg::op_item_t      q_data
);
  import swrl_pkg::*;

  logic     stg_valid;
  op_item_t stg;
  op_item_t classified;
  logic     load;

  always_comb begin
    classified.red   = item.red;
    classified.green = item.green;
    classified.blue  = item.blue;
    unique case (item.action)
      ACT_TICK:    classified.op = OP_TICK;
      ACT_SEND:    classified.op = OP_SEND;
      ACT_RAINBOW: classified.op = OP_RAINBOW;
      ACT_UNUSED:  classified.op = OP_NOP;
      default:     classified.op = OP_NOP;
    endcase
  end

  // Stage frees up when empty or when its transaction moves into the queue
  assign load   = !stg_valid || !q_full;
  assign full   = !load;
  assign q_push = stg_valid;
  assign q_data = stg;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (load) begin
      stg_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      stg <= classified;
    end
  end
endmodule
`default_nettype wire

// File: hdl/swrl_back.sv
// Back end: frame sequencer, one tick or command per cycle unless stalled.
`default_nettype none
module swrl_back #(
  parameter int TIMER_WIDTH = swrl_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire swrl_pkg::cfg_t     cfg,
  input  wire logic               q_empty,
  input  wire swrl_pkg::op_item_t q_data,
  output logic                    q_pop,
  input  wire logic               r_full,
  output logic                    r_push,
  output swrl_pkg::result_t       r_data
);
  import swrl_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HIGH1 = 3'd1;
  localparam logic [2:0] PH_LOWZ  = 3'd2;
  localparam logic [2:0] PH_LOW1  = 3'd3;
  localparam logic [2:0] PH_HIGH2 = 3'd4;
  localparam logic [2:0] PH_LOW2  = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  localparam logic [15:0] TMAX = 16'((32'd1 << TIMER_WIDTH) - 32'd1);

  function automatic logic [TIMER_WIDTH-1:0] load_dur(input logic [7:0] v);
    logic [15:0] d;
    d = 16'(v);
    if (d == 16'd0) begin
      d = 16'd1;
    end
    if (d > TMAX) begin
      d = TMAX;
    end
    return TIMER_WIDTH'(d);
  endfunction

  logic [FRAME_LEN-1:0]   frame_bits, frame_bits_next;
  logic [5:0]             bits_remaining, bits_remaining_next;
  logic [2:0]             phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_counter, tick_counter_next;
  logic [3:0]             rainbow_index, rainbow_index_next;

  logic       go;
  logic       busy;
  logic       level;
  logic [5:0] rem_dec;
  logic [3:0] g_idx, b_idx;
  logic [7:0] st_red, st_green, st_blue;
  result_t    res;

  assign go     = !q_empty && !r_full;
  assign q_pop  = go;
  assign r_push = go;
  assign r_data = res;

  assign busy    = (phase != PH_IDLE);
  assign level   = (phase == PH_HIGH1) || (phase == PH_HIGH2);
  assign rem_dec = (bits_remaining != 6'd0) ? bits_remaining - 6'd1 : 6'd0;
  assign g_idx   = (rainbow_index >= 4'd4) ? rainbow_index - 4'd4 : rainbow_index + 4'd8;
  assign b_idx   = (rainbow_index >= 4'd8) ? rainbow_index - 4'd8 : rainbow_index + 4'd4;

  always_comb begin
    if (q_data.op == OP_RAINBOW) begin
      st_red   = rainbow_color(rainbow_index);
      st_green = rainbow_color(g_idx);
      st_blue  = rainbow_color(b_idx);
    end else begin
      st_red   = q_data.red;
      st_green = q_data.green;
      st_blue  = q_data.blue;
    end
  end

  always_comb begin
    frame_bits_next     = frame_bits;
    bits_remaining_next = bits_remaining;
    phase_next          = phase;
    tick_counter_next   = tick_counter;
    rainbow_index_next  = rainbow_index;
    res                 = '0;
    unique case (q_data.op)
      OP_TICK: begin
        if (busy) begin
          res.pin_level = level;
          res.busy_res  = 1'b1;
          if (tick_counter > TIMER_WIDTH'(1)) begin
            tick_counter_next = tick_counter - TIMER_WIDTH'(1);
          end else begin
            case (phase)
              PH_HIGH1: begin
                if (frame_bits[FRAME_LEN-1]) begin
                  phase_next        = PH_LOW1;
                  tick_counter_next = load_dur(cfg.one_low_ticks);
                end else begin
                  phase_next        = PH_LOWZ;
                  tick_counter_next = load_dur(cfg.zero_low_ticks);
                end
              end
              PH_LOW1: begin
                phase_next        = PH_HIGH2;
                tick_counter_next = load_dur(cfg.pulse_high_ticks);
              end
              PH_HIGH2: begin
                phase_next        = PH_LOW2;
                tick_counter_next = load_dur(cfg.one_low_ticks);
              end
              PH_LOWZ, PH_LOW2: begin
                // shift out the finished bit
                frame_bits_next     = {frame_bits[FRAME_LEN-2:0], 1'b0};
                bits_remaining_next = rem_dec;
                if (rem_dec == 6'd0) begin
                  phase_next        = PH_END;
                  tick_counter_next = load_dur(cfg.end_low_ticks);
                end else begin
                  phase_next        = PH_HIGH1;
                  tick_counter_next = load_dur(cfg.pulse_high_ticks);
                end
              end
              default: begin
                phase_next          = PH_IDLE;
                tick_counter_next   = '0;
                frame_bits_next     = '0;
                bits_remaining_next = '0;
                res.frame_done      = 1'b1;
              end
            endcase
          end
        end
      end
      OP_SEND, OP_RAINBOW: begin
        res.busy_res = 1'b1;
        if (!busy) begin
          res.accepted        = 1'b1;
          frame_bits_next     = FRAME_LEN'({cfg.command_byte, st_red, st_green, st_blue});
          bits_remaining_next = 6'(FRAME_LEN);
          phase_next          = PH_HIGH1;
          tick_counter_next   = load_dur(cfg.pulse_high_ticks);
          if (q_data.op == OP_RAINBOW) begin
            rainbow_index_next = (rainbow_index == 4'(RAINBOW_LEN - 1)) ?
                                 4'd0 : rainbow_index + 4'd1;
          end
        end else begin
          res.pin_level = level;
        end
      end
      OP_NOP: begin
        res.pin_level = level;
        res.busy_res  = busy;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits     <= '0;
      bits_remaining <= '0;
      phase          <= PH_IDLE;
      tick_counter   <= '0;
      rainbow_index  <= '0;
    end else if (go) begin
      frame_bits     <= frame_bits_next;
      bits_remaining <= bits_remaining_next;
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      rainbow_index  <= rainbow_index_next;
    end
  end
endmodule
`default_nettype wire

// File: hdl/single_wire_rgb_led_sender_top.sv
// Path: an accepted item is held in the front stage register, then in the operation queue;
// its result is written to the result queue, whose head is on the result port.
// Throughput: one item per cycle while the result queue has room; the back-end sequencer
// handles one tick or command per pop, stalling on an empty op queue or a full result queue.
// Reset: rst (synchronous) empties both queues, puts the sequencer idle with rainbow index 0,
// and loads the registers with their reset values.
`default_nettype none
module single_wire_rgb_led_sender_top #(
  parameter int TIMER_WIDTH = swrl_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = swrl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire swrl_pkg::in_item_t                item,
  input  wire logic                              pop,
  output logic                                   empty,
  output swrl_pkg::result_t                      result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [swrl_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [swrl_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic      [swrl_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                                   pready
);
  import swrl_pkg::*;

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       wr_en;

  logic       oq_push, oq_full, oq_pop, oq_empty;
  op_item_t   oq_wdata, oq_rdata;
  logic       rq_push, rq_full;
  result_t    rq_wdata, rq_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_WIDTH-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_high_ticks <= 8'd1;
      cfg.zero_low_ticks   <= 8'd5;
      cfg.one_low_ticks    <= 8'd2;
      cfg.end_low_ticks    <= 8'd24;
      cfg.command_byte     <= 8'h3a;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE_HIGH: cfg.pulse_high_ticks <= pwdata[7:0];
        REG_ZERO_LOW:   cfg.zero_low_ticks   <= pwdata[7:0];
        REG_ONE_LOW:    cfg.one_low_ticks    <= pwdata[7:0];
        REG_END_LOW:    cfg.end_low_ticks    <= pwdata[7:0];
        REG_COMMAND:    cfg.command_byte     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULSE_HIGH: prdata = DATA_WIDTH'(cfg.pulse_high_ticks);
      REG_ZERO_LOW:   prdata = DATA_WIDTH'(cfg.zero_low_ticks);
      REG_ONE_LOW:    prdata = DATA_WIDTH'(cfg.one_low_ticks);
      REG_END_LOW:    prdata = DATA_WIDTH'(cfg.end_low_ticks);
      REG_COMMAND:    prdata = DATA_WIDTH'(cfg.command_byte);
      default:        prdata = '0;
    endcase
  end

  swrl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (oq_push),
    .q_full (oq_full),
    .q_data (oq_wdata)
  );

  swrl_fifo #(
    .WIDTH ($bits(op_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .full  (oq_full),
    .wdata (oq_wdata),
    .pop   (oq_pop),
    .empty (oq_empty),
    .rdata (oq_rdata)
  );

  swrl_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (oq_empty),
    .q_data  (oq_rdata),
    .q_pop   (oq_pop),
    .r_full  (rq_full),
    .r_push  (rq_push),
    .r_data  (rq_wdata)
  );

  swrl_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .full  (rq_full),
    .wdata (rq_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (rq_rdata)
  );

  assign result = rq_rdata;
endmodule
`default_nettype wire
